// ===== src/rcq_pkg.sv =====
// rcq_pkg: shared types and fixed constants for the ring command queue
// depends on nothing; used by the controller, datapath and top level

package rcq_pkg;

    // fixed field widths
    localparam int unsigned CAP_BITS   = 9;
    localparam int unsigned LIMIT_BITS = 5;

    // capacity_in_use after reset
    localparam logic [CAP_BITS-1:0] CAP_RESET = 9'd256;

    // operation codes
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic push;        // write slot at tail, advance tail, bump fill
        logic pop_take;    // read slot at head, advance head, drop fill
        logic clr_wake;    // clear the wake flag
        logic out_load;    // load the result register
        logic out_status;
        logic out_wake;
        logic out_has;
        logic out_last;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic q_empty;
        logic q_full;
        logic fill_one;
        logic wake;
    } t_dp_status;

endpackage

// ===== src/rcq_if.sv =====
// rcq_in_if / rcq_out_if: valid/ready channels for items and results
// depends on nothing

interface rcq_in_if #(
    parameter int unsigned COMMAND_BITS = 64
);
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic [COMMAND_BITS-1:0] command_word;
    logic [4:0]              batch_limit;

    modport source (output valid, kind, command_word, batch_limit, input ready);
    modport sink   (input valid, kind, command_word, batch_limit, output ready);
endinterface

interface rcq_out_if #(
    parameter int unsigned COMMAND_BITS = 64
);
    logic                    valid;
    logic                    ready;
    logic                    status;
    logic                    wake_req;
    logic                    has_command;
    logic [COMMAND_BITS-1:0] popped_command;
    logic                    last;

    modport source (output valid, status, wake_req, has_command, popped_command, last,
                    input ready);
    modport sink   (input valid, status, wake_req, has_command, popped_command, last,
                    output ready);
endinterface

// ===== src/rcq_ctrl.sv =====
// rcq_ctrl: item sequencer for push and batch pop, owns the result valid
// depends on rcq_pkg

module rcq_ctrl #(
    parameter int unsigned MAX_BATCH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_kind,
    input  logic [rcq_pkg::LIMIT_BITS-1:0]   i_limit,
    output logic                             o_in_ready,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    input  rcq_pkg::t_dp_status              i_dp_status,
    output rcq_pkg::t_dp_cmd                 o_dp_cmd
);
    import rcq_pkg::*;

    localparam int unsigned BAT_W = $clog2(MAX_BATCH + 1);
    localparam int unsigned LIM_W = (BAT_W > LIMIT_BITS) ? BAT_W : LIMIT_BITS;
    localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_BATCH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [BAT_W-1:0] r_rem, n_rem;
    logic             r_out_valid, n_out_valid;
    logic             slot_free;
    logic             accept;
    logic [LIM_W-1:0] lim_ext;
    logic [BAT_W-1:0] lim_sat;
    logic             pop_last;

    assign slot_free = !r_out_valid || i_out_ready;
    assign accept    = i_in_valid && o_in_ready;
    assign lim_ext   = LIM_W'(i_limit);
    assign lim_sat   = (lim_ext > MAX_LIM) ? BAT_W'(MAX_LIM) : BAT_W'(lim_ext);
    assign pop_last  = (r_rem == BAT_W'(1)) || i_dp_status.fill_one;

    assign o_in_ready  = (r_state == S_IDLE) && slot_free;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state  = r_state;
        n_rem    = r_rem;
        o_dp_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_kind == KIND_PUSH) begin
                        o_dp_cmd.push       = !i_dp_status.q_full;
                        o_dp_cmd.out_load   = 1'b1;
                        o_dp_cmd.out_status = i_dp_status.q_full ? STATUS_FULL : STATUS_OK;
                        o_dp_cmd.out_wake   = !i_dp_status.q_full && !i_dp_status.wake;
                        o_dp_cmd.out_last   = 1'b1;
                    end else if (lim_sat == '0) begin
                        // zero limit: empty answer, no state change
                        o_dp_cmd.out_load = 1'b1;
                        o_dp_cmd.out_last = 1'b1;
                    end else if (i_dp_status.q_empty) begin
                        o_dp_cmd.out_load = 1'b1;
                        o_dp_cmd.out_last = 1'b1;
                        o_dp_cmd.clr_wake = 1'b1;
                    end else begin
                        n_rem   = lim_sat;
                        n_state = S_POP;
                    end
                end
            end
            S_POP: begin
                if (slot_free) begin
                    o_dp_cmd.pop_take = 1'b1;
                    o_dp_cmd.out_load = 1'b1;
                    o_dp_cmd.out_has  = 1'b1;
                    o_dp_cmd.out_last = pop_last;
                    o_dp_cmd.clr_wake = i_dp_status.fill_one;
                    n_rem             = r_rem - BAT_W'(1);
                    if (pop_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_dp_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rem       <= n_rem;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== src/rcq_dp.sv =====
// rcq_dp: slot memory, ring indexes, fill count, wake flag, result register
// depends on rcq_pkg

module rcq_dp #(
    parameter int unsigned DEPTH        = 256,
    parameter int unsigned COMMAND_BITS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rcq_pkg::CAP_BITS-1:0]   i_cfg_data,
    input  logic [COMMAND_BITS-1:0]        i_command_word,
    input  rcq_pkg::t_dp_cmd               i_dp_cmd,
    output rcq_pkg::t_dp_status            o_dp_status,
    output logic                           o_status,
    output logic                           o_wake_req,
    output logic                           o_has_command,
    output logic [COMMAND_BITS-1:0]        o_popped_command,
    output logic                           o_last
);
    import rcq_pkg::*;

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    logic [COMMAND_BITS-1:0] r_mem [DEPTH];
    logic [COMMAND_BITS-1:0] r_rd_data;

    logic [CAP_BITS-1:0] r_cap;
    logic [IDX_W-1:0]    r_head, n_head;
    logic [IDX_W-1:0]    r_tail, n_tail;
    logic [CNT_W-1:0]    r_fill, n_fill;
    logic                r_wake, n_wake;
    logic                r_status, r_out_wake, r_has, r_last;

    logic [CMP_W-1:0] cap_ext;
    logic [CNT_W-1:0] act_cap;
    logic [CNT_W-1:0] head_inc, tail_inc;

    // clamp capacity into 1..DEPTH
    assign cap_ext = CMP_W'(r_cap);
    always_comb begin
        if (cap_ext == '0) begin
            act_cap = CNT_W'(1);
        end else if (cap_ext > DEPTH_C) begin
            act_cap = CNT_W'(DEPTH_C);
        end else begin
            act_cap = CNT_W'(cap_ext);
        end
    end

    assign head_inc = CNT_W'(r_head) + CNT_W'(1);
    assign tail_inc = CNT_W'(r_tail) + CNT_W'(1);

    assign o_dp_status.q_empty  = (r_fill == '0);
    assign o_dp_status.q_full   = (r_fill >= act_cap);
    assign o_dp_status.fill_one = (r_fill == CNT_W'(1));
    assign o_dp_status.wake     = r_wake;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        n_wake = r_wake;
        if (i_dp_cmd.push) begin
            n_tail = (tail_inc == act_cap) ? '0 : IDX_W'(tail_inc);
            n_fill = r_fill + CNT_W'(1);
            n_wake = 1'b1;
        end
        if (i_dp_cmd.pop_take) begin
            n_head = (head_inc == act_cap) ? '0 : IDX_W'(head_inc);
            n_fill = r_fill - CNT_W'(1);
        end
        if (i_dp_cmd.clr_wake) begin
            n_wake = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CAP_RESET;
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
            r_wake <= 1'b0;
        end else if (i_cfg_we) begin
            // a capacity write also empties the queue
            r_cap  <= i_cfg_data;
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
            r_wake <= 1'b0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
            r_wake <= n_wake;
        end
    end

    // slot memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.push) begin
            r_mem[r_tail] <= i_command_word;
        end
        if (i_dp_cmd.pop_take) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.out_load) begin
            r_status   <= i_dp_cmd.out_status;
            r_out_wake <= i_dp_cmd.out_wake;
            r_has      <= i_dp_cmd.out_has;
            r_last     <= i_dp_cmd.out_last;
        end
    end

    assign o_status         = r_status;
    assign o_wake_req       = r_out_wake;
    assign o_has_command    = r_has;
    assign o_popped_command = r_has ? r_rd_data : '0;
    assign o_last           = r_last;

endmodule

// ===== src/ring_command_queue_batch_pop.sv =====
// ring_command_queue_batch_pop: circular command queue with batch pop
// depends on rcq_pkg, rcq_if, rcq_ctrl, rcq_dp
// push: the result is registered and valid in the cycle after the item is taken; pop: the item
//   is taken, S_POP starts, then one slot read per cycle while the result register is free;
//   no new item is taken until the batch ends; a result left waiting holds the input back
// reset: synchronous; indexes, fill count, wake flag, result valid cleared; capacity 256

module ring_command_queue_batch_pop #(
    parameter int unsigned DEPTH        = 256,
    parameter int unsigned COMMAND_BITS = 64,
    parameter int unsigned MAX_BATCH    = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    rcq_in_if.sink                       i_in,
    rcq_out_if.source                    o_out,
    input  logic                         i_cfg_we,
    input  logic [rcq_pkg::CAP_BITS-1:0] i_cfg_data
);
    import rcq_pkg::*;

    // command and status between the sequencer and the storage side
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // sequencer: takes one item at a time, walks a pop batch one slot per cycle,
    // and holds the result valid until taken; a new result loads only when the
    // result register is empty or being emptied
    rcq_ctrl #(
        .MAX_BATCH (MAX_BATCH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_kind      (i_in.kind),
        .i_limit     (i_in.batch_limit),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_dp_status (dp_status),
        .o_dp_cmd    (dp_cmd)
    );

    // storage: slot memory with registered read feeding the result directly,
    // ring pointers wrap at the clamped capacity, not at the built depth
    rcq_dp #(
        .DEPTH        (DEPTH),
        .COMMAND_BITS (COMMAND_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_command_word   (i_in.command_word),
        .i_dp_cmd         (dp_cmd),
        .o_dp_status      (dp_status),
        .o_status         (o_out.status),
        .o_wake_req       (o_out.wake_req),
        .o_has_command    (o_out.has_command),
        .o_popped_command (o_out.popped_command),
        .o_last           (o_out.last)
    );

endmodule
